// ===== rtl/cbd_pkg.sv =====
// Shared constants, register codes and types of the correlation bit demodulator.
package cbd_pkg;

  // Correlation, sum and threshold width (product scale, LSB = 2^-30 at 16-bit samples)
  localparam int CORR_W = 48;
  // samples_per_bit register width
  localparam int SPB_W = 13;
  localparam logic [SPB_W-1:0] SPB_RESET = 13'd100;

  // Parameter defaults
  localparam int DEF_MAX_SAMPLES_PER_BIT = 4096;
  localparam int DEF_SAMPLE_WIDTH = 16;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Configuration port
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FSK_MODE        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES_PER_BIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD       = 2'd2;

  // Result item: decided_bit, correlation, padded to whole bytes
  localparam int OUT_TDATA_W = ((CORR_W + 1 + 7) / 8) * 8;

  // Decision settings handed to the back end
  typedef struct packed {
    logic                     fsk_mode;
    logic signed [CORR_W-1:0] threshold;
  } cbd_dec_cfg_t;

endpackage

// ===== rtl/correlation_bit_demodulator.sv =====
// Top level of the integrate-and-dump correlation bit demodulator.
// Takes one sample item (received sample, reference A, reference B) per clock
// cycle with no gaps needed while out_tready does not hold results back: the
// front end forms both products, a four-item queue decouples it from the back
// end, which integrates the products and, after samples_per_bit items, puts
// out one result item (decided bit and 48-bit correlation). Sustained rate is
// one item per cycle while out_tready stays high. The last sample of a bit
// passes the front stage register, the queue and the dump, correlation and
// output registers before out_tvalid rises. In FSK mode the correlation is
// the B sum minus the A sum, otherwise the A sum; the bit is one when the
// correlation is at or above the threshold. Write configuration only while
// the block is idle; there is no start-up clearing pass.
module correlation_bit_demodulator #(
  parameter int MAX_SAMPLES_PER_BIT = cbd_pkg::DEF_MAX_SAMPLES_PER_BIT,
  parameter int SAMPLE_WIDTH        = cbd_pkg::DEF_SAMPLE_WIDTH,
  parameter int IN_TDATA_W          = ((3 * SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // rx_sample, ref_a_sample, ref_b_sample from the lowest bit up
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [IN_TDATA_W-1:0]              in_tdata,
  // decided_bit, correlation from the lowest bit up
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [cbd_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [cbd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cbd_pkg::CORR_W-1:0]         cfg_data
);

  localparam int ITEM_W = 4 * SAMPLE_WIDTH + 1;

  logic                         fsk_mode_r;
  logic [cbd_pkg::SPB_W-1:0]    spb_r;
  logic [cbd_pkg::CORR_W-1:0]   threshold_r;
  cbd_pkg::cbd_dec_cfg_t        dec_cfg;
  logic                         f_valid, f_ready, b_valid, b_ready;
  logic [ITEM_W-1:0]            f_data, b_data;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsk_mode_r  <= 1'b0;
      spb_r       <= cbd_pkg::SPB_RESET;
      threshold_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        cbd_pkg::CFG_FSK_MODE:        fsk_mode_r  <= cfg_data[0];
        cbd_pkg::CFG_SAMPLES_PER_BIT: spb_r       <= cfg_data[cbd_pkg::SPB_W-1:0];
        cbd_pkg::CFG_THRESHOLD:       threshold_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign dec_cfg.fsk_mode  = fsk_mode_r;
  assign dec_cfg.threshold = threshold_r;

  cbd_front #(
    .MAX_SAMPLES_PER_BIT (MAX_SAMPLES_PER_BIT),
    .SAMPLE_WIDTH        (SAMPLE_WIDTH),
    .IN_W                (IN_TDATA_W),
    .ITEM_W              (ITEM_W)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .samples_per_bit (spb_r),
    .in_valid        (in_tvalid),
    .in_ready        (in_tready),
    .in_data         (in_tdata),
    .item_valid      (f_valid),
    .item_ready      (f_ready),
    .item_data       (f_data)
  );

  cbd_queue #(
    .WIDTH (ITEM_W),
    .DEPTH (cbd_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_data),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (b_data)
  );

  cbd_back #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .ITEM_W       (ITEM_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .dec_cfg    (dec_cfg),
    .item_valid (b_valid),
    .item_ready (b_ready),
    .item_data  (b_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== rtl/cbd_front.sv =====
// Front end: takes sample items, forms both products and marks the last item of a bit.
module cbd_front #(
  parameter int MAX_SAMPLES_PER_BIT = cbd_pkg::DEF_MAX_SAMPLES_PER_BIT,
  parameter int SAMPLE_WIDTH        = cbd_pkg::DEF_SAMPLE_WIDTH,
  parameter int IN_W                = ((3 * SAMPLE_WIDTH + 7) / 8) * 8,
  parameter int ITEM_W              = 4 * SAMPLE_WIDTH + 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [cbd_pkg::SPB_W-1:0]   samples_per_bit,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [IN_W-1:0]             in_data,
  output logic                        item_valid,
  input  logic                        item_ready,
  output logic [ITEM_W-1:0]           item_data
);

  localparam int PROD_W = 2 * SAMPLE_WIDTH;
  localparam int CNT_W  = $clog2(MAX_SAMPLES_PER_BIT);
  localparam int MAX_W  = $clog2(MAX_SAMPLES_PER_BIT + 1);
  localparam int LEN_W  = (MAX_W > cbd_pkg::SPB_W) ? MAX_W : cbd_pkg::SPB_W;

  logic signed [SAMPLE_WIDTH-1:0] rx_s, ref_a_s, ref_b_s;
  logic signed [PROD_W-1:0]       prod_a, prod_b;
  logic signed [PROD_W-1:0]       prod_a_r, prod_b_r;
  logic                           last_r, valid_r;
  logic [CNT_W-1:0]               cnt_r, cnt_nxt;
  logic [LEN_W-1:0]               spb_ext, len_eff, cnt_inc;
  logic                           is_last, accept;

  // Unpack the sample item
  assign rx_s    = in_data[SAMPLE_WIDTH-1:0];
  assign ref_a_s = in_data[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
  assign ref_b_s = in_data[3*SAMPLE_WIDTH-1:2*SAMPLE_WIDTH];

  assign prod_a = rx_s * ref_a_s;
  assign prod_b = rx_s * ref_b_s;

  // Effective bit length: zero acts as one, large values clamp to the maximum
  assign spb_ext = LEN_W'(samples_per_bit);
  always_comb begin
    if (samples_per_bit == '0) begin
      len_eff = LEN_W'(1);
    end else if (spb_ext > LEN_W'(MAX_SAMPLES_PER_BIT)) begin
      len_eff = LEN_W'(MAX_SAMPLES_PER_BIT);
    end else begin
      len_eff = spb_ext;
    end
  end

  // Sample counter within the bit
  assign cnt_inc = LEN_W'(cnt_r) + LEN_W'(1);
  assign is_last = (cnt_inc >= len_eff);
  assign cnt_nxt = is_last ? '0 : CNT_W'(cnt_inc);

  // Stage register is free, or empties into the queue this cycle
  assign in_ready = !valid_r || item_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      if (in_ready) begin
        valid_r <= in_valid;
      end
      if (accept) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  // Product and marker payload
  always_ff @(posedge clk) begin
    if (accept) begin
      prod_a_r <= prod_a;
      prod_b_r <= prod_b;
      last_r   <= is_last;
    end
  end

  assign item_valid = valid_r;
  assign item_data  = {last_r, prod_b_r, prod_a_r};

  // Counter never reaches the maximum length
  assert property (@(posedge clk) disable iff (!rst_n)
    LEN_W'(cnt_r) < LEN_W'(MAX_SAMPLES_PER_BIT))
    else $error("sample counter out of range");

  // A held item keeps its A product and last marker while the queue is full
  assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !item_ready |=> valid_r && $stable(prod_a_r) && $stable(last_r))
    else $error("front item changed while stalled");

  // Counter restarts after the last sample of a bit
  assert property (@(posedge clk) disable iff (!rst_n)
    accept && is_last |=> cnt_r == '0)
    else $error("counter not cleared at end of bit");

endmodule

// ===== rtl/cbd_queue.sv =====
// Short first-in first-out queue of product items between front and back.
module cbd_queue #(
  parameter int WIDTH = 65,
  parameter int DEPTH = cbd_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             push, pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = slot_r[rd_ptr_r];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue fill count above depth");

  // An empty queue has its write and read pointers equal
  assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("empty queue with pointers apart");

  assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("queue count missed a push");

endmodule

// ===== rtl/cbd_back.sv =====
// Back end: integrates products, dumps at the end of each bit and decides the bit.
module cbd_back #(
  parameter int SAMPLE_WIDTH = cbd_pkg::DEF_SAMPLE_WIDTH,
  parameter int ITEM_W       = 4 * SAMPLE_WIDTH + 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  cbd_pkg::cbd_dec_cfg_t             dec_cfg,
  input  logic                              item_valid,
  output logic                              item_ready,
  input  logic [ITEM_W-1:0]                 item_data,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [cbd_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  localparam int PROD_W = 2 * SAMPLE_WIDTH;
  localparam int CW     = cbd_pkg::CORR_W;

  logic signed [PROD_W-1:0] prod_a, prod_b;
  logic                     item_last, pop;
  logic signed [CW-1:0]     acc_a_r, acc_b_r, sum_a, sum_b;
  logic signed [CW-1:0]     fin_a_r, fin_b_r, corr_r;
  logic                     fin_v_r, corr_v_r, out_v_r;
  logic                     fin_ready, corr_ready, out_ready;
  logic signed [CW-1:0]     out_corr_r;
  logic                     out_bit_r;

  assign prod_a    = item_data[PROD_W-1:0];
  assign prod_b    = item_data[2*PROD_W-1:PROD_W];
  assign item_last = item_data[2*PROD_W];

  // Stage ready chain from the output register backwards
  assign out_ready  = !out_v_r || out_tready;
  assign corr_ready = !corr_v_r || out_ready;
  assign fin_ready  = !fin_v_r || corr_ready;

  // An ordinary item always integrates; the last one needs room in the dump stage
  assign item_ready = !item_last || fin_ready;
  assign pop        = item_valid && item_ready;

  assign sum_a = acc_a_r + CW'(prod_a);
  assign sum_b = acc_b_r + CW'(prod_b);

  // Integrators, kept modulo 2^48
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_a_r <= '0;
      acc_b_r <= '0;
    end else if (pop) begin
      acc_a_r <= item_last ? '0 : sum_a;
      acc_b_r <= item_last ? '0 : sum_b;
    end
  end

  // Valid bits of the dump, correlation and output stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_v_r  <= 1'b0;
      corr_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (fin_ready) begin
        fin_v_r <= pop && item_last;
      end
      if (corr_ready) begin
        corr_v_r <= fin_v_r;
      end
      if (out_ready) begin
        out_v_r <= corr_v_r;
      end
    end
  end

  // Dump, correlation select and decision payload
  always_ff @(posedge clk) begin
    if (pop && item_last) begin
      fin_a_r <= sum_a;
      fin_b_r <= sum_b;
    end
    if (corr_ready && fin_v_r) begin
      corr_r <= dec_cfg.fsk_mode ? (fin_b_r - fin_a_r) : fin_a_r;
    end
    if (out_ready && corr_v_r) begin
      out_corr_r <= corr_r;
      out_bit_r  <= (corr_r >= dec_cfg.threshold);
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {{(cbd_pkg::OUT_TDATA_W - CW - 1){1'b0}}, out_corr_r, out_bit_r};

  // Ending a bit leaves both integrators empty
  assert property (@(posedge clk) disable iff (!rst_n)
    pop && item_last |=> acc_a_r == '0 && acc_b_r == '0)
    else $error("integrators not dumped");

  // Only a last item can be held back at the queue head
  assert property (@(posedge clk) disable iff (!rst_n)
    item_valid && !item_ready |-> item_last && fin_v_r && corr_v_r && out_v_r)
    else $error("back end stalled with room to spare");

  // A finished dump stays put while the correlation stage is blocked
  assert property (@(posedge clk) disable iff (!rst_n)
    fin_v_r && !corr_ready |=> fin_v_r && $stable(fin_a_r) && $stable(fin_b_r))
    else $error("dumped sums lost under stall");

endmodule
